FILE: hdl/atlf_pkg.sv
// Shared types and constants for the linear fade-out unit.
package atlf_pkg;

  localparam int SAMPLE_W = 16;
  localparam int REG_W    = 30;
  localparam int COUNT_W  = REG_W + 1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [REG_W-1:0]           reg_val_t;
  typedef logic [COUNT_W-1:0]         count_t;

  // Register indexes of the configuration port.
  typedef enum logic [0:0] {
    REG_PLAY = 1'b0,
    REG_FADE = 1'b1
  } cfg_reg_t;

  // Default play and fade lengths in frames: ms times frame rate / 1000.
  localparam longint unsigned DEF_PLAY_MS = (2 * 60 + 50) * 1000;
  localparam longint unsigned DEF_FADE_MS = 10 * 1000;
  localparam longint unsigned DEF_RATE    = 44100;
  localparam reg_val_t PLAY_RESET = reg_val_t'(DEF_PLAY_MS * DEF_RATE / 1000);
  localparam reg_val_t FADE_RESET = reg_val_t'(DEF_FADE_MS * DEF_RATE / 1000);

  // Lane handshake with the controller.
  typedef struct packed {
    logic start;
    logic ack;
  } lane_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lane_stat_t;

endpackage

FILE: hdl/atlf_if.sv
// Valid/ready channel interfaces for frame requests and faded results.
interface atlf_in_if;
  import atlf_pkg::*;
  logic    valid;
  logic    ready;
  sample_t left_in;
  sample_t right_in;
  logic    discard;

  modport source (output valid, output left_in, output right_in, output discard,
                  input ready);
  modport sink   (input valid, input left_in, input right_in, input discard,
                  output ready);
endinterface

interface atlf_out_if;
  import atlf_pkg::*;
  logic    valid;
  logic    ready;
  sample_t left_out;
  sample_t right_out;
  logic    final_frame;

  modport source (output valid, output left_out, output right_out,
                  output final_frame, input ready);
  modport sink   (input valid, input left_out, input right_out,
                  input final_frame, output ready);
endinterface

FILE: hdl/atlf_lane.sv
// One fade lane: magnitude multiply, then 16-step restoring divide.
module atlf_lane (
  input  logic                 clk,
  input  logic                 rst_n,
  input  atlf_pkg::lane_ctl_t  ctl,
  input  atlf_pkg::sample_t    sample,
  input  atlf_pkg::reg_val_t   remain,
  input  atlf_pkg::reg_val_t   len,
  output atlf_pkg::lane_stat_t stat,
  output atlf_pkg::sample_t    result
);
  import atlf_pkg::*;

  localparam int PROD_W = SAMPLE_W + REG_W;
  localparam int STEP_W = $clog2(SAMPLE_W);

  typedef enum logic [1:0] {L_IDLE, L_MUL, L_DIV, L_DONE} lane_state_t;

  lane_state_t              state_r;
  logic                     neg_r;
  logic [SAMPLE_W-1:0]      mag_r;
  reg_val_t                 remain_r;
  reg_val_t                 len_r;
  logic [REG_W-1:0]         rem_r;
  logic [SAMPLE_W-1:0]      low_r;
  logic [STEP_W-1:0]        step_r;
  sample_t                  result_r;

  logic [PROD_W-1:0]        prod;
  logic [REG_W:0]           trial;
  logic [REG_W:0]           diff;
  logic                     ge;
  logic [SAMPLE_W-1:0]      quo;

  assign prod  = PROD_W'(mag_r) * PROD_W'(remain_r);
  assign trial = {rem_r, low_r[SAMPLE_W-1]};
  assign diff  = trial - {1'b0, len_r};
  assign ge    = (trial >= {1'b0, len_r});
  assign quo   = {low_r[SAMPLE_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
    end else begin
      case (state_r)
        L_IDLE: begin
          if (ctl.start) begin
            neg_r    <= sample[SAMPLE_W-1];
            mag_r    <= sample[SAMPLE_W-1] ? SAMPLE_W'(-sample) : SAMPLE_W'(sample);
            remain_r <= remain;
            len_r    <= len;
            state_r  <= L_MUL;
          end
        end
        L_MUL: begin
          // quotient fits 16 bits, so the top bits are already below len
          rem_r   <= prod[PROD_W-1:SAMPLE_W];
          low_r   <= prod[SAMPLE_W-1:0];
          step_r  <= STEP_W'(SAMPLE_W - 1);
          state_r <= L_DIV;
        end
        L_DIV: begin
          rem_r  <= ge ? diff[REG_W-1:0] : trial[REG_W-1:0];
          low_r  <= quo;
          step_r <= step_r - 1'b1;
          if (step_r == '0) begin
            result_r <= neg_r ? sample_t'(-quo) : sample_t'(quo);
            state_r  <= L_DONE;
          end
        end
        L_DONE: begin
          if (ctl.ack) begin
            state_r <= L_IDLE;
          end
        end
        default: state_r <= L_IDLE;
      endcase
    end
  end

  assign stat.busy = (state_r != L_IDLE);
  assign stat.done = (state_r == L_DONE);
  assign result    = result_r;

endmodule

FILE: hdl/audio_track_linear_fade_out_unit.sv
// Top level of the linear fade-out unit: frame counter, two fade lanes, merge and output register.
//
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+----------------------------------
//  in_req    | in  | valid / ready      | left_in, right_in, discard
//  out_res   | out | valid / ready      | left_out, right_out, final_frame
//  cfg_*     | in  | cfg_we (no ready)  | cfg_index, cfg_data
//
//  Only one request is in flight at a time. A pass-through frame goes from
//  the held request to the result register in the merge state; a faded frame
//  takes 1 multiply and 16 divide steps in each lane, then done and merge.
//  Discarded, and finished-track, requests complete at the accept edge.
//  Reset is synchronous (rst_n low) and restores the default lengths and
//  a zero frame count. A stalled result holds in the output register while
//  the next request is already taken in.
module audio_track_linear_fade_out_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  atlf_in_if.sink               in_req,
  atlf_out_if.source            out_res,
  input  logic                  cfg_we,
  input  atlf_pkg::cfg_reg_t    cfg_index,
  input  atlf_pkg::reg_val_t    cfg_data
);
  import atlf_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_CALC, S_MERGE} state_t;

  state_t     state_r;
  reg_val_t   play_r;
  reg_val_t   fade_len_r;
  count_t     count_r;

  // held request
  sample_t    left_r;
  sample_t    right_r;
  logic       final_r;
  logic       do_fade_r;

  // output register
  logic       out_valid_r;
  sample_t    out_left_r;
  sample_t    out_right_r;
  logic       out_final_r;

  count_t     total;
  count_t     count_nxt;
  reg_val_t   remain;
  logic       accept;
  logic       active;
  logic       in_fade;
  logic       emit;
  logic       load_out;

  lane_ctl_t  lane_ctl;
  lane_stat_t stat_l;
  lane_stat_t stat_r;
  sample_t    res_l;
  sample_t    res_r;

  assign total     = {1'b0, play_r} + {1'b0, fade_len_r};
  assign count_nxt = count_r + 1'b1;
  assign remain    = reg_val_t'(total - count_r);
  assign accept    = in_req.valid && in_req.ready;
  assign active    = (count_r < total);
  assign in_fade   = (count_r >= {1'b0, play_r});
  assign emit      = accept && active && !in_req.discard;
  assign load_out  = (state_r == S_MERGE) && (!out_valid_r || out_res.ready);

  assign lane_ctl.start = emit && in_fade;
  assign lane_ctl.ack   = load_out && do_fade_r;

  atlf_lane u_lane_l (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (lane_ctl),
    .sample (in_req.left_in),
    .remain (remain),
    .len    (fade_len_r),
    .stat   (stat_l),
    .result (res_l)
  );

  atlf_lane u_lane_r (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (lane_ctl),
    .sample (in_req.right_in),
    .remain (remain),
    .len    (fade_len_r),
    .stat   (stat_r),
    .result (res_r)
  );

  // Config registers; the user must write them only while idle, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      play_r     <= PLAY_RESET;
      fade_len_r <= FADE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PLAY: play_r     <= cfg_data;
        REG_FADE: fade_len_r <= cfg_data;
        default:  ;
      endcase
    end
  end

  // Controller, frame count and merge into the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a new result loads into an empty register or replaces the one just taken
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept && active) begin
            count_r <= count_nxt;   // saturates: no advance once finished
          end
          if (emit) begin
            left_r    <= in_req.left_in;
            right_r   <= in_req.right_in;
            final_r   <= (count_nxt == total);
            do_fade_r <= in_fade;
            state_r   <= in_fade ? S_CALC : S_MERGE;
          end
        end
        S_CALC: begin
          if (stat_l.done && stat_r.done) begin
            state_r <= S_MERGE;
          end
        end
        S_MERGE: begin
          if (load_out) begin
            out_left_r  <= do_fade_r ? res_l : left_r;
            out_right_r <= do_fade_r ? res_r : right_r;
            out_final_r <= final_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_req.ready        = (state_r == S_IDLE);
  assign out_res.valid       = out_valid_r;
  assign out_res.left_out    = out_left_r;
  assign out_res.right_out   = out_right_r;
  assign out_res.final_frame = out_final_r;

endmodule

FILE: hdl/atlf_checker.sv
// Port-level checks for the linear fade-out unit, bound to the top level.
module atlf_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_discard,
  input logic              out_valid,
  input logic              out_ready,
  input atlf_pkg::sample_t out_left,
  input atlf_pkg::sample_t out_right,
  input logic              out_final
);
  import atlf_pkg::*;

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_left) && $stable(out_right) && $stable(out_final))
    else $error("stalled result changed");

  // a discard request never produces a result
  a_discard_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_discard |=> !$rose(out_valid))
    else $error("result after discard request");

  // a new result is only loaded while no request is being taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result loaded while idle");

endmodule

bind audio_track_linear_fade_out_unit atlf_checker u_atlf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_req.valid),
  .in_ready   (in_req.ready),
  .in_discard (in_req.discard),
  .out_valid  (out_res.valid),
  .out_ready  (out_res.ready),
  .out_left   (out_res.left_out),
  .out_right  (out_res.right_out),
  .out_final  (out_res.final_frame)
);
